[design/r_type_execute_unit_top_macros.svh]
// Assertion macros for the R-type execute unit checker
`ifndef R_TYPE_EXECUTE_UNIT_TOP_MACROS_SVH
`define R_TYPE_EXECUTE_UNIT_TOP_MACROS_SVH

`define RTEU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define RTEU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[design/rteu_pkg.sv]
// Package with types, codes and constants of the R-type execute unit
`timescale 1ns / 1ps
package rteu_pkg;

    localparam int unsigned DATA_W      = 32;
    localparam int unsigned DIV_STAGES  = 32;
    localparam int unsigned QUEUE_DEPTH = 4;

    typedef enum logic [5:0] {
        FN_SLL   = 6'd0,
        FN_SRL   = 6'd2,
        FN_SRA   = 6'd3,
        FN_SLLV  = 6'd4,
        FN_SRLV  = 6'd6,
        FN_SRAV  = 6'd7,
        FN_MULT  = 6'd24,
        FN_MULTU = 6'd25,
        FN_DIV   = 6'd26,
        FN_DIVU  = 6'd27,
        FN_ADD   = 6'd32,
        FN_ADDU  = 6'd33,
        FN_SUB   = 6'd34,
        FN_SUBU  = 6'd35,
        FN_AND   = 6'd36,
        FN_OR    = 6'd37,
        FN_XOR   = 6'd38,
        FN_SLT   = 6'd42,
        FN_SLTU  = 6'd43
    } funct_t;

    typedef enum logic [1:0] {
        ERR_OK       = 2'd0,
        ERR_OVERFLOW = 2'd1,
        ERR_UNKNOWN  = 2'd2
    } err_t;

    typedef enum logic [2:0] {
        CLS_ALU,
        CLS_MUL,
        CLS_DIV,
        CLS_OVF,
        CLS_BAD
    } class_t;

    typedef struct packed {
        logic [5:0]  op;
        logic [31:0] rs_value;
        logic [31:0] rt_value;
        logic [4:0]  shamt;
    } in_item_t;

    typedef struct packed {
        logic [31:0] result_low;
        logic [31:0] result_high;
        logic        writes_hilo;
        logic [1:0]  error;
    } out_item_t;

    typedef struct packed {
        class_t      cls;
        logic        sgn;
        logic [31:0] alu;
        logic [31:0] a;
        logic [31:0] b;
    } cmd_t;

endpackage

[design/rteu_front.sv]
// Front end: decode the function, compute ALU results and classify the request
`timescale 1ns / 1ps
module rteu_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  rteu_pkg::in_item_t in_item,
    output logic               in_ready,
    output logic               cmd_valid,
    output rteu_pkg::cmd_t     cmd,
    input  logic               cmd_ready
);
    import rteu_pkg::*;

    logic        valid_reg;
    cmd_t        cmd_reg;
    cmd_t        cmd_next;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] sum;
    logic [31:0] dif;
    logic [4:0]  amt;
    logic [31:0] sra_v;

    assign a       = in_item.rs_value;
    assign b       = in_item.rt_value;
    assign sum     = a + b;
    assign dif     = a - b;
    assign amt     = (in_item.op[2]) ? a[4:0] : in_item.shamt;
    assign sra_v   = 32'($signed(b) >>> amt);
    assign in_ready = !valid_reg || cmd_ready;

    always_comb
    begin
        cmd_next     = '0;
        cmd_next.cls = CLS_ALU;
        cmd_next.a   = a;
        cmd_next.b   = b;
        unique case (in_item.op)
            FN_SLL, FN_SLLV: cmd_next.alu = b << amt;
            FN_SRL, FN_SRLV: cmd_next.alu = b >> amt;
            FN_SRA, FN_SRAV: cmd_next.alu = sra_v;
            FN_MULT:  begin cmd_next.cls = CLS_MUL; cmd_next.sgn = 1'b1; end
            FN_MULTU: cmd_next.cls = CLS_MUL;
            FN_DIV:   begin cmd_next.cls = CLS_DIV; cmd_next.sgn = 1'b1; end
            FN_DIVU:  cmd_next.cls = CLS_DIV;
            FN_ADD:
            begin
                if ((a[31] ~^ b[31]) && (sum[31] != a[31])) cmd_next.cls = CLS_OVF;
                else cmd_next.alu = sum;
            end
            FN_ADDU:  cmd_next.alu = sum;
            FN_SUB:
            begin
                if ((a[31] ^ b[31]) && (dif[31] != a[31])) cmd_next.cls = CLS_OVF;
                else cmd_next.alu = dif;
            end
            FN_SUBU:  cmd_next.alu = dif;
            FN_AND:   cmd_next.alu = a & b;
            FN_OR:    cmd_next.alu = a | b;
            FN_XOR:   cmd_next.alu = a ^ b;
            FN_SLT:   cmd_next.alu = {31'd0, $signed(a) < $signed(b)};
            FN_SLTU:  cmd_next.alu = {31'd0, a < b};
            default:  cmd_next.cls = CLS_BAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;
endmodule

[design/rteu_queue.sv]
// Short request queue between front and back
`timescale 1ns / 1ps
module rteu_queue
#(
    parameter int unsigned DEPTH = rteu_pkg::QUEUE_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    input  rteu_pkg::cmd_t wr_data,
    output logic           wr_ready,
    output logic           rd_valid,
    output rteu_pkg::cmd_t rd_data,
    input  logic           rd_ready
);
    import rteu_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cmd_t            mem [DEPTH];
    logic [AW-1:0]   wp_reg;
    logic [AW-1:0]   rp_reg;
    logic [AW:0]     cnt_reg;
    logic            do_wr;
    logic            do_rd;

    assign wr_ready = cnt_reg != (AW+1)'(DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;
    assign rd_data  = mem[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr) wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            if (do_rd) rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(do_wr) - (AW+1)'(do_rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr) mem[wp_reg] <= wr_data;
    end
endmodule

[design/rteu_back.sv]
// Back end: pipelined multiply and restoring divide, result register
`timescale 1ns / 1ps
module rteu_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    input  rteu_pkg::cmd_t        cmd,
    output logic                  cmd_ready,
    output logic                  out_valid,
    output rteu_pkg::out_item_t   out_item,
    input  logic                  out_ready
);
    import rteu_pkg::*;

    localparam int unsigned NS = DIV_STAGES + 3;

    typedef struct packed {
        class_t      cls;
        logic        qneg;
        logic        rneg;
        logic        bzero;
        logic [31:0] alu;
        logic [31:0] b;
        logic [31:0] q;
        logic [31:0] r;
        logic [15:0][31:0] pp;
    } st_t;

    logic              v_reg [NS];
    st_t               s_reg [NS];
    st_t               s_next [NS];
    logic              adv;
    logic              out_v_reg;
    out_item_t         out_reg;
    out_item_t         fin;
    logic [63:0]       prod;
    logic [63:0]       row;
    logic [32:0]       trial;
    logic [31:0]       ra;
    logic [31:0]       rb;

    assign adv       = !out_v_reg || out_ready;
    assign cmd_ready = adv;
    assign out_valid = out_v_reg;
    assign out_item  = out_reg;

    always_comb
    begin
        ra = (cmd.sgn && cmd.a[31]) ? (~cmd.a + 32'd1) : cmd.a;
        rb = (cmd.sgn && cmd.b[31]) ? (~cmd.b + 32'd1) : cmd.b;
        s_next[0]       = '0;
        s_next[0].cls   = cmd.cls;
        s_next[0].alu   = cmd.alu;
        s_next[0].qneg  = cmd.sgn && (cmd.a[31] != cmd.b[31]);
        s_next[0].rneg  = cmd.sgn && cmd.a[31];
        s_next[0].bzero = cmd.b == '0;
        s_next[0].b     = rb;
        s_next[0].q     = ra;
        s_next[0].pp    = '0;
        s_next[1]       = s_reg[0];
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                s_next[1].pp[i*4+j] = 32'({16'd0, s_reg[0].q[i*8 +: 8]}
                                          * {16'd0, s_reg[0].b[j*8 +: 8]});
            end
        end
        for (int k = 2; k < NS - 1; k++)
        begin
            s_next[k] = s_reg[k-1];
            trial = {s_reg[k-1].r, s_reg[k-1].q[31]} - {1'b0, s_reg[k-1].b};
            if (s_reg[k-1].cls == CLS_DIV)
            begin
                if (!trial[32])
                begin
                    s_next[k].r = trial[31:0];
                    s_next[k].q = {s_reg[k-1].q[30:0], 1'b1};
                end
                else
                begin
                    s_next[k].r = {s_reg[k-1].r[30:0], s_reg[k-1].q[31]};
                    s_next[k].q = {s_reg[k-1].q[30:0], 1'b0};
                end
            end
        end
        for (int i = 0; i < 4; i++)
        begin
            row = '0;
            for (int j = 0; j < 4; j++)
            begin
                row = row + (64'(s_reg[1].pp[i*4+j]) << (8*j));
            end
            s_next[2].pp[i*2]   = row[31:0];
            s_next[2].pp[i*2+1] = row[63:32];
        end
        s_next[NS-1] = s_reg[NS-2];
        prod = '0;
        for (int i = 0; i < 4; i++)
        begin
            prod = prod + ({s_reg[NS-2].pp[i*2+1], s_reg[NS-2].pp[i*2]} << (8*i));
        end
        if (s_reg[NS-2].qneg) prod = ~prod + 64'd1;
        s_next[NS-1].pp[0] = prod[31:0];
        s_next[NS-1].pp[1] = prod[63:32];
    end

    always_comb
    begin
        fin = '0;
        unique case (s_reg[NS-1].cls)
            CLS_ALU: fin.result_low = s_reg[NS-1].alu;
            CLS_MUL:
            begin
                fin.result_low  = s_reg[NS-1].pp[0];
                fin.result_high = s_reg[NS-1].pp[1];
                fin.writes_hilo = 1'b1;
            end
            CLS_DIV:
            begin
                fin.writes_hilo = 1'b1;
                if (!s_reg[NS-1].bzero)
                begin
                    fin.result_low  = s_reg[NS-1].qneg ? (~s_reg[NS-1].q + 32'd1)
                                                       : s_reg[NS-1].q;
                    fin.result_high = s_reg[NS-1].rneg ? (~s_reg[NS-1].r + 32'd1)
                                                       : s_reg[NS-1].r;
                end
            end
            CLS_OVF: fin.error = ERR_OVERFLOW;
            default: fin.error = ERR_UNKNOWN;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NS; k++) v_reg[k] <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= cmd_valid;
            for (int k = 1; k < NS; k++) v_reg[k] <= v_reg[k-1];
            out_v_reg <= v_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < NS; k++) s_reg[k] <= s_next[k];
            out_reg <= fin;
        end
    end
endmodule

[design/r_type_execute_unit_top.sv]
// Top level of the R-type execute unit
//  channel | direction | handshake      | payload
//  input   | in        | push / full    | in_item  (op, rs_value, rt_value, shamt)
//  result  | out       | pop / empty    | out_item (result_low, result_high, hilo, error)
// One request per cycle sustained while results are popped; all requests traverse
// the unrolled one-bit-per-stage divider, whatever the op.
// Reset clears all valid bits and queue pointers; payload registers are not reset.
// A stalled pop holds the back pipeline, then backs up through the request queue and the front.
`timescale 1ns / 1ps
module r_type_execute_unit_top
#(
    parameter int unsigned QUEUE_DEPTH = rteu_pkg::QUEUE_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  rteu_pkg::in_item_t  in_item,
    output logic                empty,
    input  logic                pop,
    output rteu_pkg::out_item_t out_item
);
    import rteu_pkg::*;

    logic f_valid;
    cmd_t f_cmd;
    logic f_ready;
    logic q_valid;
    cmd_t q_cmd;
    logic q_ready;
    logic in_ready;
    logic out_valid;

    rteu_front u_front
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(push), .in_item(in_item), .in_ready(in_ready),
        .cmd_valid(f_valid), .cmd(f_cmd), .cmd_ready(f_ready)
    );

    rteu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_data(f_cmd), .wr_ready(f_ready),
        .rd_valid(q_valid), .rd_data(q_cmd), .rd_ready(q_ready)
    );

    rteu_back u_back
    (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(q_valid), .cmd(q_cmd), .cmd_ready(q_ready),
        .out_valid(out_valid), .out_item(out_item), .out_ready(pop)
    );

    assign full  = !in_ready;
    assign empty = !out_valid;
endmodule

[design/rteu_checker.sv]
// Port-level checker for the R-type execute unit and its bind
`timescale 1ns / 1ps
`include "r_type_execute_unit_top_macros.svh"
module rteu_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                push,
    input logic                full,
    input logic                empty,
    input logic                pop,
    input rteu_pkg::out_item_t out_item
);
    import rteu_pkg::*;

    `RTEU_ASSERT_IMPL(a_err_code, clk, rst_n, !empty, out_item.error != 2'd3)
    `RTEU_ASSERT_IMPL(a_err_zero, clk, rst_n, !empty && out_item.error != ERR_OK, out_item.result_low == '0 && out_item.result_high == '0 && !out_item.writes_hilo)
    `RTEU_ASSERT_NEXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(out_item))
    `RTEU_ASSERT_IMPL(a_full_known, clk, rst_n, push, !$isunknown(full))
endmodule

bind r_type_execute_unit_top rteu_checker u_checker
(
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .empty(empty), .pop(pop), .out_item(out_item)
);

[tb/sv/r_type_execute_unit_top_test.sv]
// Self-checking testbench for the R-type execute unit: random and directed requests
`timescale 1ns / 1ps
module r_type_execute_unit_top_test;
    import rteu_pkg::*;

    class alu_scoreboard;
        out_item_t pending[$];
        int        mismatches;

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= 50) $display("mismatch: %s", msg);
        endtask

        function out_item_t compute(in_item_t req);
            out_item_t   r;
            logic [31:0] a;
            logic [31:0] b;
            logic [31:0] s;
            logic [31:0] ma;
            logic [31:0] mb;
            logic [31:0] q;
            logic [31:0] m;
            logic [63:0] p;
            logic [4:0]  vsh;
            a = req.rs_value;
            b = req.rt_value;
            vsh = a[4:0];
            r = '0;
            r.error = ERR_OK;
            case (req.op)
                FN_SLL:   r.result_low = b << req.shamt;
                FN_SRL:   r.result_low = b >> req.shamt;
                FN_SRA:   r.result_low = $signed(b) >>> req.shamt;
                FN_SLLV:  r.result_low = b << vsh;
                FN_SRLV:  r.result_low = b >> vsh;
                FN_SRAV:  r.result_low = $signed(b) >>> vsh;
                FN_MULT:
                begin
                    p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                    {r.result_high, r.result_low} = p;
                    r.writes_hilo = 1'b1;
                end
                FN_MULTU:
                begin
                    p = {32'd0, a} * {32'd0, b};
                    {r.result_high, r.result_low} = p;
                    r.writes_hilo = 1'b1;
                end
                FN_DIV:
                begin
                    r.writes_hilo = 1'b1;
                    if (b != 0)
                    begin
                        ma = a[31] ? -a : a;
                        mb = b[31] ? -b : b;
                        q = ma / mb;
                        m = ma % mb;
                        r.result_low = (a[31] != b[31]) ? -q : q;
                        r.result_high = a[31] ? -m : m;
                    end
                end
                FN_DIVU:
                begin
                    r.writes_hilo = 1'b1;
                    if (b != 0)
                    begin
                        r.result_low = a / b;
                        r.result_high = a % b;
                    end
                end
                FN_ADD:
                begin
                    s = a + b;
                    if (a[31] == b[31] && s[31] != a[31]) r.error = ERR_OVERFLOW;
                    else r.result_low = s;
                end
                FN_ADDU:  r.result_low = a + b;
                FN_SUB:
                begin
                    s = a - b;
                    if (a[31] != b[31] && s[31] != a[31]) r.error = ERR_OVERFLOW;
                    else r.result_low = s;
                end
                FN_SUBU:  r.result_low = a - b;
                FN_AND:   r.result_low = a & b;
                FN_OR:    r.result_low = a | b;
                FN_XOR:   r.result_low = a ^ b;
                FN_SLT:   r.result_low = {31'd0, $signed(a) < $signed(b)};
                FN_SLTU:  r.result_low = {31'd0, a < b};
                default:  r.error = ERR_UNKNOWN;
            endcase
            return r;
        endfunction

        function void note_request(in_item_t req);
            pending.push_back(compute(req));
        endfunction

        task check_result(out_item_t got);
            out_item_t want;
            if (pending.size() == 0)
            begin
                report_mismatch("result with no request outstanding");
                return;
            end
            want = pending.pop_front();
            if (got.result_low !== want.result_low)
                report_mismatch($sformatf("result_low %h want %h", got.result_low,
                                          want.result_low));
            if (got.result_high !== want.result_high)
                report_mismatch($sformatf("result_high %h want %h", got.result_high,
                                          want.result_high));
            if (got.writes_hilo !== want.writes_hilo)
                report_mismatch($sformatf("writes_hilo %b want %b", got.writes_hilo,
                                          want.writes_hilo));
            if (got.error !== want.error)
                report_mismatch($sformatf("error %0d want %0d", got.error, want.error));
        endtask
    endclass

    logic      clk;
    logic      rst_n;
    logic      push;
    logic      full;
    in_item_t  in_item;
    logic      empty;
    logic      pop;
    out_item_t out_item;

    alu_scoreboard sb;
    int        send_idle_pct;
    int        recv_stall_pct;

    r_type_execute_unit_top dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_item  (in_item),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item)
    );

    always #1 clk = ~clk;

    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    localparam logic [5:0] KNOWN_OPS [19] = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV,
        FN_SRAV, FN_MULT, FN_MULTU, FN_DIV, FN_DIVU, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU,
        FN_AND, FN_OR, FN_XOR, FN_SLT, FN_SLTU};

    function logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return $urandom_range(0, 40);
            5: return -$urandom_range(1, 40);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_request(logic [5:0] op, logic [31:0] a, logic [31:0] b,
                                logic [4:0] sh);
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        in_item <= '{op: op, rs_value: a, rt_value: b, shamt: sh};
        @(posedge clk);
        while (full) @(posedge clk);
        sb.note_request(in_item);
    endtask

    task automatic send_random();
        logic [5:0] op;
        if ($urandom_range(0, 19) == 0) op = 6'($urandom_range(0, 63));
        else op = KNOWN_OPS[$urandom_range(0, 18)];
        send_request(op, pick_operand(), pick_operand(), 5'($urandom_range(0, 31)));
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty) sb.check_result(out_item);
            pop <= !(recv_stall_pct > 0 && $urandom_range(0, 99) < recv_stall_pct);
        end
    end

    initial
    begin
        int i;
        int waited;
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        in_item = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (i = 0; i < 19; i++)
            send_request(KNOWN_OPS[i], 32'h8000_0005, 32'hFFFF_FFFD, 5'd31);
        send_request(FN_ADD, 32'h7FFF_FFFF, 32'h1, 5'd0);
        send_request(FN_SUB, 32'h8000_0000, 32'h1, 5'd0);
        send_request(FN_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 5'd0);
        send_request(FN_DIV, 32'h1234_5678, 32'h0, 5'd0);
        send_request(FN_DIVU, 32'hFFFF_FFFF, 32'h0, 5'd0);
        send_request(6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);
        for (i = 0; i < 1150; i++)
        begin
            case (i / 290)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            send_random();
        end
        push <= 1'b0;
        recv_stall_pct = 0;
        waited = 0;
        while (sb.pending.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (50) @(posedge clk);
        if (sb.pending.size() != 0) sb.report_mismatch("requests left without results");
        if (sb.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
